/* rtl/quaternion_to_ned_attitude_unit_assert.svh */
// Assertion macros for the quaternion to NED attitude unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef QUATERNION_TO_NED_ATTITUDE_UNIT_ASSERT_SVH
`define QUATERNION_TO_NED_ATTITUDE_UNIT_ASSERT_SVH

// same-cycle implication
`define Q2N_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define Q2N_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/q2n_pkg.sv */
// Shared types and constants for the quaternion to NED attitude unit.
// No dependencies; imported by every module of the unit.
package q2n_pkg;

	localparam int ADDR_W = 5;
	localparam int CFG_W = 48;
	localparam int CFG_N = 3;
	localparam int B_W = 16;
	localparam int B_FRAC = 14;
	localparam int ANG_W = 34;
	localparam int ATAN_N = 24;
	localparam int SCALE_LEN = 30;

	localparam logic [1:0] REG_ROW0 = 2'd0;
	localparam logic [1:0] REG_ROW1 = 2'd1;
	localparam logic [1:0] REG_ROW2 = 2'd2;

	localparam logic [CFG_W-1:0] ROW0_RST = 48'h0000_0000_4000;
	localparam logic [CFG_W-1:0] ROW1_RST = 48'h0000_4000_0000;
	localparam logic [CFG_W-1:0] ROW2_RST = 48'h4000_0000_0000;

	typedef struct packed {
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
		logic signed [31:0] pos_wx;
		logic signed [31:0] pos_wy;
		logic signed [31:0] pos_wz;
		logic signed [31:0] vel_wx;
		logic signed [31:0] vel_wy;
		logic signed [31:0] vel_wz;
		logic [63:0] stamp_in;
		logic [31:0] gen_in;
	} est_t;

	typedef struct packed {
		logic [63:0] stamp_out;
		logic [31:0] gen_out;
		logic signed [31:0] pos_north;
		logic signed [31:0] pos_east;
		logic signed [31:0] pos_down;
		logic signed [31:0] vel_north;
		logic signed [31:0] vel_east;
		logic signed [31:0] vel_down;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic bad_quat;
	} att_t;

	function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
		return (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
	endfunction

	// atan(2^-i) with pi = 2^31
	function automatic logic [29:0] atan_entry(input int i);
		case (i)
			0: return 30'd536870912;
			1: return 30'd316933406;
			2: return 30'd167458907;
			3: return 30'd85004756;
			4: return 30'd42667331;
			5: return 30'd21354465;
			6: return 30'd10679838;
			7: return 30'd5340245;
			8: return 30'd2670163;
			9: return 30'd1335087;
			10: return 30'd667544;
			11: return 30'd333772;
			12: return 30'd166886;
			13: return 30'd83443;
			14: return 30'd41722;
			15: return 30'd20861;
			16: return 30'd10430;
			17: return 30'd5215;
			18: return 30'd2608;
			19: return 30'd1304;
			20: return 30'd652;
			21: return 30'd326;
			22: return 30'd163;
			23: return 30'd81;
			default: return 30'd0;
		endcase
	endfunction

endpackage

/* rtl/q2n_div_cell.sv */
// One quotient bit of the pipelined restoring divider.
// Depends on q2n_pkg; chained by the top level, one cell per bit.
module q2n_div_cell import q2n_pkg::*; #(
	parameter int RMW = 62,
	parameter int DW = 48,
	parameter int QW = 15,
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic [RMW-1:0] rem,
	input logic [DW-1:0] dvs,
	input logic [QW-1:0] quo,
	input logic neg,
	output logic [RMW-1:0] rem_q,
	output logic [DW-1:0] dvs_q,
	output logic [QW-1:0] quo_q,
	output logic neg_q
);

	localparam int K = QW - 1 - STEP;

	logic [RMW-1:0] trial;
	logic fit;

	assign trial = RMW'(dvs) << K;
	assign fit = (rem >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fit ? (rem - trial) : rem;
			quo_q <= {quo[QW-2:0], fit};
			dvs_q <= dvs;
			neg_q <= neg;
		end
	end

endmodule

/* rtl/q2n_sqrt_cell.sv */
// One digit step of the pipelined integer square root.
// Depends on q2n_pkg; chained by the top level, one cell per result bit.
module q2n_sqrt_cell import q2n_pkg::*; #(
	parameter int VW = 30,
	parameter int SQW = 15,
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic [VW-1:0] rem,
	input logic [VW-1:0] res,
	output logic [VW-1:0] rem_q,
	output logic [VW-1:0] res_q
);

	localparam int K = SQW - 1 - STEP;
	localparam logic [VW-1:0] ONE = VW'(1) << (2 * K);

	logic [VW-1:0] trial;
	logic fit;

	assign trial = res + ONE;
	assign fit = (rem >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fit ? (rem - trial) : rem;
			res_q <= fit ? ((res >> 1) + ONE) : (res >> 1);
		end
	end

endmodule

/* rtl/q2n_cordic_cell.sv */
// One vectoring iteration of the CORDIC arctangent.
// Depends on q2n_pkg for the angle table and angle width.
module q2n_cordic_cell import q2n_pkg::*; #(
	parameter int CW = 22,
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic signed [CW-1:0] x,
	input logic signed [CW-1:0] y,
	input logic signed [ANG_W-1:0] ang,
	input logic nul,
	output logic signed [CW-1:0] x_q,
	output logic signed [CW-1:0] y_q,
	output logic signed [ANG_W-1:0] ang_q,
	output logic nul_q
);

	localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_entry(STEP));

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	assign dx = x >>> STEP;
	assign dy = y >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y[CW-1]) begin
				x_q <= x + dy;
				y_q <= y - dx;
				ang_q <= ang + ATAN;
			end else begin
				x_q <= x - dy;
				y_q <= y + dx;
				ang_q <= ang - ATAN;
			end
			nul_q <= nul;
		end
	end

endmodule

/* rtl/quaternion_to_ned_attitude_unit.sv */
// Top level: quaternion pose estimate to NED roll, pitch, yaw and position/velocity.
// Depends on q2n_pkg, q2n_div_cell, q2n_sqrt_cell and q2n_cordic_cell.
//
// channel | dir | handshake           | payload
// est     | in  | est_valid/est_ready | est_t
// att     | out | att_valid/att_ready | att_t
// cfg     | in  | APB psel/penable    | paddr/pwdata/prdata, 64-bit
//
// One transaction per cycle while the output is not stalled; the pipeline runs through
// the divider cells, the square root cells and the CORDIC cells.
// Reset clears the valid bits and the output valid, and sets the body rows to identity.
// A stalled output holds; the pipeline keeps advancing while its last stage is empty, and
// est_ready drops only when the output register is stalled and the last stage is full.
module quaternion_to_ned_attitude_unit import q2n_pkg::*; #(
	parameter int CORDIC_STAGES = 16,
	parameter int MATRIX_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic est_valid,
	output logic est_ready,
	input est_t est,
	output logic att_valid,
	input logic att_ready,
	output att_t att,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	localparam int F = MATRIX_FRAC_BITS;
	localparam int NC = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
	localparam int QSW = 31;
	localparam int PW = 62;
	localparam int NW = 63;
	localparam int RMW = 63;
	localparam int DW = RMW - F;
	localparam int QW = F + 1;
	localparam int RW = F + 2;
	localparam int SW = F + 20;
	localparam int MW = SW - B_FRAC;
	localparam int VW = 2 * F + 2;
	localparam int SQW = F + 1;
	localparam int CW = F + 8;
	localparam int BNW = ANG_W - 16;
	localparam int DEPTH = 6 + QW + 5 + SQW + 1 + NC;
	localparam int MD = SQW + 2;
	localparam int YD = SQW + 1;

	localparam logic signed [MW-1:0] LIM_M = MW'(longint'(1) <<< F);
	localparam logic [VW-1:0] LIM_SQ = VW'(1) << (2 * F);
	localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(longint'(1) <<< 31);
	localparam logic signed [ANG_W-1:0] RND = ANG_W'(32768);
	localparam logic signed [BNW-1:0] PLIM = BNW'(16384);

	// configuration
	logic [CFG_W-1:0] row_q [CFG_N];
	logic [1:0] cfg_idx;
	logic cfg_wr;

	assign cfg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ROW0: row_q[0] <= pwdata[CFG_W-1:0];
				REG_ROW1: row_q[1] <= pwdata[CFG_W-1:0];
				REG_ROW2: row_q[2] <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ROW0: prdata = 64'(row_q[0]);
			REG_ROW1: prdata = 64'(row_q[1]);
			REG_ROW2: prdata = 64'(row_q[2]);
			default: prdata = '0;
		endcase
	end

	// flow control
	logic [DEPTH-1:0] vld_q;
	att_t side_q [DEPTH];
	logic att_valid_q;
	att_t att_q;
	logic take;
	logic en;

	assign take = !att_valid_q || att_ready;
	assign en = take || !vld_q[DEPTH-1];
	assign est_ready = en;
	assign att_valid = att_valid_q;
	assign att = att_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], est_valid};
		end
	end

	att_t side_in;

	always_comb begin
		side_in.stamp_out = est.stamp_in;
		side_in.gen_out = est.gen_in;
		side_in.pos_north = est.pos_wy;
		side_in.pos_east = est.pos_wx;
		side_in.pos_down = neg_sat32(est.pos_wz);
		side_in.vel_north = est.vel_wy;
		side_in.vel_east = est.vel_wx;
		side_in.vel_down = neg_sat32(est.vel_wz);
		side_in.roll = '0;
		side_in.pitch = '0;
		side_in.yaw = '0;
		side_in.bad_quat = (est.quat_x == '0) && (est.quat_y == '0) &&
			(est.quat_z == '0) && (est.quat_w == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int i = 1; i < DEPTH; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// magnitude OR gives the bit length of the largest component
	logic signed [31:0] q_s1 [4];
	logic [31:0] or_s1;
	logic [31:0] mag_or;
	logic signed [31:0] q_in [4];

	assign q_in[0] = est.quat_x;
	assign q_in[1] = est.quat_y;
	assign q_in[2] = est.quat_z;
	assign q_in[3] = est.quat_w;

	always_comb begin
		mag_or = '0;
		for (int i = 0; i < 4; i++) begin
			mag_or = mag_or | (q_in[i][31] ? 32'(-q_in[i]) : 32'(q_in[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= q_in;
			or_s1 <= mag_or;
		end
	end

	logic signed [31:0] q_s2 [4];
	logic [5:0] len_s2;
	logic [5:0] len;

	always_comb begin
		len = '0;
		for (int i = 0; i < 32; i++) begin
			if (or_s1[i]) len = 6'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= q_s1;
			len_s2 <= len;
		end
	end

	logic signed [QSW-1:0] q_s3 [4];
	logic signed [QSW-1:0] qs [4];
	logic signed [63:0] wq;
	logic signed [63:0] sh;

	always_comb begin
		wq = '0;
		sh = '0;
		for (int i = 0; i < 4; i++) begin
			wq = 64'(q_s2[i]);
			if (len_s2 > 6'(SCALE_LEN)) sh = wq >>> (len_s2 - 6'(SCALE_LEN));
			else sh = wq <<< (6'(SCALE_LEN) - len_s2);
			qs[i] = sh[QSW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) q_s3 <= qs;
	end

	logic signed [PW-1:0] xx_s4, yy_s4, zz_s4, ww_s4, xy_s4, wz_s4, xz_s4, wy_s4, yz_s4, wx_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s4 <= q_s3[0] * q_s3[0];
			yy_s4 <= q_s3[1] * q_s3[1];
			zz_s4 <= q_s3[2] * q_s3[2];
			ww_s4 <= q_s3[3] * q_s3[3];
			xy_s4 <= q_s3[0] * q_s3[1];
			wz_s4 <= q_s3[3] * q_s3[2];
			xz_s4 <= q_s3[0] * q_s3[2];
			wy_s4 <= q_s3[3] * q_s3[1];
			yz_s4 <= q_s3[1] * q_s3[2];
			wx_s4 <= q_s3[3] * q_s3[0];
		end
	end

	logic signed [NW-1:0] num_s5 [9];
	logic [RMW-1:0] n2_s5;
	logic signed [63:0] t [9];
	logic [63:0] n2;

	always_comb begin
		t[0] = 64'(ww_s4) + 64'(xx_s4) - 64'(yy_s4) - 64'(zz_s4);
		t[1] = (64'(xy_s4) - 64'(wz_s4)) <<< 1;
		t[2] = (64'(xz_s4) + 64'(wy_s4)) <<< 1;
		t[3] = (64'(xy_s4) + 64'(wz_s4)) <<< 1;
		t[4] = 64'(ww_s4) - 64'(xx_s4) + 64'(yy_s4) - 64'(zz_s4);
		t[5] = (64'(yz_s4) - 64'(wx_s4)) <<< 1;
		t[6] = (64'(xz_s4) - 64'(wy_s4)) <<< 1;
		t[7] = (64'(yz_s4) + 64'(wx_s4)) <<< 1;
		t[8] = 64'(ww_s4) - 64'(xx_s4) - 64'(yy_s4) + 64'(zz_s4);
		n2 = 64'(xx_s4) + 64'(yy_s4) + 64'(zz_s4) + 64'(ww_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) num_s5[i] <= t[i][NW-1:0];
			n2_s5 <= n2[RMW-1:0];
		end
	end

	logic [RMW-1:0] mag_s6 [9];
	logic neg_s6 [9];
	logic [DW-1:0] d_s6;
	logic signed [NW-1:0] ng [9];

	always_comb begin
		for (int i = 0; i < 9; i++) ng[i] = -num_s5[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				mag_s6[i] <= num_s5[i][NW-1] ? ng[i][RMW-1:0] : num_s5[i][RMW-1:0];
				neg_s6[i] <= num_s5[i][NW-1];
			end
			d_s6 <= n2_s5[RMW-1:F];
		end
	end

	// divider chains, one per matrix entry
	logic [RMW-1:0] dv_rem [9][QW+1];
	logic [DW-1:0] dv_d [9][QW+1];
	logic [QW-1:0] dv_quo [9][QW+1];
	logic dv_neg [9][QW+1];

	for (genvar l = 0; l < 9; l++) begin : g_div
		assign dv_rem[l][0] = mag_s6[l];
		assign dv_d[l][0] = d_s6;
		assign dv_quo[l][0] = '0;
		assign dv_neg[l][0] = neg_s6[l];
		for (genvar s = 0; s < QW; s++) begin : g_bit
			q2n_div_cell #(.RMW(RMW), .DW(DW), .QW(QW), .STEP(s)) u_cell (
				.clk(clk),
				.en(en),
				.rem(dv_rem[l][s]),
				.dvs(dv_d[l][s]),
				.quo(dv_quo[l][s]),
				.neg(dv_neg[l][s]),
				.rem_q(dv_rem[l][s+1]),
				.dvs_q(dv_d[l][s+1]),
				.quo_q(dv_quo[l][s+1]),
				.neg_q(dv_neg[l][s+1])
			);
		end
	end

	logic signed [RW-1:0] r_sr [9];
	logic signed [RW-1:0] ru [9];

	always_comb begin
		for (int i = 0; i < 9; i++) ru[i] = {1'b0, dv_quo[i][QW]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) r_sr[i] <= dv_neg[i][QW] ? -ru[i] : ru[i];
		end
	end

	// products with body rows: M10, M00, M20, M21, M22 in that order
	logic signed [B_W-1:0] b_m [3][3];
	logic signed [RW+B_W-1:0] prd_sp1 [5][3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) b_m[j][k] = row_q[j][16*k +: 16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 5; m++) begin
				for (int k = 0; k < 3; k++) begin
					prd_sp1[m][k] <= r_sr[3 * ((m < 2) ? m : 2) + k] *
						b_m[(m < 2) ? 0 : m - 2][k];
				end
			end
		end
	end

	logic signed [MW-1:0] m_sp2 [5];
	logic signed [SW-1:0] sm [5];
	logic signed [SW-1:0] sms [5];

	always_comb begin
		for (int m = 0; m < 5; m++) begin
			sm[m] = SW'(prd_sp1[m][0]) + SW'(prd_sp1[m][1]) + SW'(prd_sp1[m][2]);
			if (m >= 2) sm[m] = -sm[m];
			sms[m] = sm[m] >>> B_FRAC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 5; m++) m_sp2[m] <= sms[m][MW-1:0];
		end
	end

	// clamp, square and delay of the angle inputs
	logic signed [RW-1:0] m20c_sc;
	logic signed [MW-1:0] cl;
	logic signed [MW-1:0] mdly_q [MD][4];

	always_comb begin
		if (m_sp2[2] > LIM_M) cl = LIM_M;
		else if (m_sp2[2] < -LIM_M) cl = -LIM_M;
		else cl = m_sp2[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m20c_sc <= cl[RW-1:0];
			mdly_q[0][0] <= m_sp2[1];
			mdly_q[0][1] <= m_sp2[0];
			mdly_q[0][2] <= m_sp2[3];
			mdly_q[0][3] <= m_sp2[4];
			for (int i = 1; i < MD; i++) mdly_q[i] <= mdly_q[i-1];
		end
	end

	logic [VW-1:0] sq_sq;
	logic signed [2*RW-1:0] msq;
	logic signed [RW-1:0] yd_q [YD];

	assign msq = m20c_sc * m20c_sc;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_sq <= LIM_SQ - msq[VW-1:0];
			yd_q[0] <= m20c_sc;
			for (int i = 1; i < YD; i++) yd_q[i] <= yd_q[i-1];
		end
	end

	logic [VW-1:0] sr_rem [SQW+1];
	logic [VW-1:0] sr_res [SQW+1];

	assign sr_rem[0] = sq_sq;
	assign sr_res[0] = '0;

	for (genvar s = 0; s < SQW; s++) begin : g_sqrt
		q2n_sqrt_cell #(.VW(VW), .SQW(SQW), .STEP(s)) u_cell (
			.clk(clk),
			.en(en),
			.rem(sr_rem[s]),
			.res(sr_res[s]),
			.rem_q(sr_rem[s+1]),
			.res_q(sr_res[s+1])
		);
	end

	// CORDIC lanes: roll, pitch, yaw
	logic signed [CW-1:0] vy [3];
	logic signed [CW-1:0] vx [3];
	logic signed [CW-1:0] cpx_q [3];
	logic signed [CW-1:0] cpy_q [3];
	logic signed [ANG_W-1:0] cpa_q [3];
	logic cpz_q [3];

	always_comb begin
		vy[0] = CW'(mdly_q[MD-1][2]);
		vx[0] = CW'(mdly_q[MD-1][3]);
		vy[1] = CW'(yd_q[YD-1]);
		vx[1] = {1'b0, sr_res[SQW][CW-2:0]};
		vy[2] = CW'(mdly_q[MD-1][1]);
		vx[2] = CW'(mdly_q[MD-1][0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				cpz_q[l] <= (vx[l] == '0) && (vy[l] == '0);
				if (vx[l][CW-1]) begin
					cpx_q[l] <= -vx[l];
					cpy_q[l] <= -vy[l];
					cpa_q[l] <= vy[l][CW-1] ? -HALF_TURN : HALF_TURN;
				end else begin
					cpx_q[l] <= vx[l];
					cpy_q[l] <= vy[l];
					cpa_q[l] <= '0;
				end
			end
		end
	end

	logic signed [CW-1:0] cx [3][NC+1];
	logic signed [CW-1:0] cy [3][NC+1];
	logic signed [ANG_W-1:0] ca [3][NC+1];
	logic cz [3][NC+1];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign cx[l][0] = cpx_q[l];
		assign cy[l][0] = cpy_q[l];
		assign ca[l][0] = cpa_q[l];
		assign cz[l][0] = cpz_q[l];
		for (genvar s = 0; s < NC; s++) begin : g_step
			q2n_cordic_cell #(.CW(CW), .STEP(s)) u_cell (
				.clk(clk),
				.en(en),
				.x(cx[l][s]),
				.y(cy[l][s]),
				.ang(ca[l][s]),
				.nul(cz[l][s]),
				.x_q(cx[l][s+1]),
				.y_q(cy[l][s+1]),
				.ang_q(ca[l][s+1]),
				.nul_q(cz[l][s+1])
			);
		end
	end

	// round to 16-bit binary angles
	logic signed [ANG_W-1:0] ar [3];
	logic signed [BNW-1:0] bn [3];
	logic signed [BNW-1:0] asn;
	logic signed [BNW-1:0] pneg;
	att_t fin;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ar[l] = (ca[l][NC] + RND) >>> 16;
			bn[l] = cz[l][NC] ? '0 : ar[l][BNW-1:0];
		end
		if (bn[1] > PLIM) asn = PLIM;
		else if (bn[1] < -PLIM) asn = -PLIM;
		else asn = bn[1];
		pneg = -asn;
		fin = side_q[DEPTH-1];
		if (!fin.bad_quat) begin
			fin.roll = bn[0][15:0];
			fin.pitch = pneg[15:0];
			fin.yaw = bn[2][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_valid_q <= 1'b0;
		end else if (take) begin
			att_valid_q <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (take && vld_q[DEPTH-1]) att_q <= fin;
	end

endmodule

/* rtl/q2n_checker.sv */
// Port-level checks for the quaternion to NED attitude unit, bound to the top level.
// Depends on q2n_pkg and quaternion_to_ned_attitude_unit_assert.svh.
`include "quaternion_to_ned_attitude_unit_assert.svh"

module q2n_checker import q2n_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic est_ready,
	input logic att_valid,
	input logic att_ready,
	input att_t att
);

	`Q2N_ASSERT_NOW(a_ready_drop, !est_ready, att_valid && !att_ready, "est_ready low without output stall")
	`Q2N_ASSERT_NEXT(a_out_hold, att_valid && !att_ready, att_valid && $stable(att), "stalled transaction changed")
	`Q2N_ASSERT_NOW(a_bad_zero, att_valid && att.bad_quat, att.roll == 16'sd0 && att.pitch == 16'sd0 && att.yaw == 16'sd0, "angles nonzero on zero quaternion")
	`Q2N_ASSERT_NOW(a_pitch_range, att_valid, att.pitch <= 16'sd16384 && att.pitch >= -16'sd16384, "pitch out of range")

endmodule

bind quaternion_to_ned_attitude_unit q2n_checker u_q2n_checker (
	.clk(clk),
	.arst_n(arst_n),
	.est_ready(est_ready),
	.att_valid(att_valid),
	.att_ready(att_ready),
	.att(att)
);

/* test/tb.sv */
// Testbench for quaternion_to_ned_attitude_unit: random and directed pose estimates,
// APB writes of the body rows, result checks against an in-bench attitude predictor.
// Depends on q2n_pkg and the unit's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import q2n_pkg::*;

	localparam int STAGES = 16;
	localparam int FRAC = 14;
	localparam int LATENCY = 2 * FRAC + STAGES + 15;
	localparam longint LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic est_valid = 0;
	logic est_ready;
	est_t est = '0;
	logic att_valid;
	logic att_ready = 0;
	att_t att;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	int errors = 0;
	longint cycles = 0;
	int hold_off = 0;
	bit hold_go = 0;
	bit hold_done = 0;
	bit rx_busy_free = 0;
	int n_sent = 0, n_bad = 0, n_cfg = 0;

	const longint ATAN[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	always #6 clk = ~clk;

	quaternion_to_ned_attitude_unit #(.CORDIC_STAGES(STAGES), .MATRIX_FRAC_BITS(FRAC)) DUT (
		.clk, .arst_n, .est_valid, .est_ready, .est, .att_valid, .att_ready, .att,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	function automatic longint sra(input longint v, input int k);
		return v >>> k;
	endfunction

	function automatic longint vec_angle(input longint y0, input longint x0);
		longint a, x, y, dx, dy;
		a = 0; x = x0; y = y0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			a = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
			x = -x; y = -y;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = sra(x, i); dy = sra(y, i);
			if (y >= 0) begin
				x += dy; y -= dx; a += ATAN[i];
			end else begin
				x -= dy; y += dx; a -= ATAN[i];
			end
		end
		return sra(a + 32768, 16);
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res, one;
		res = 0; one = 64'd1 << 62;
		while (one > v) one >>= 2;
		while (one != 0) begin
			if (v >= res + one) begin
				v -= res + one; res = (res >> 1) + one;
			end else res >>= 1;
			one >>= 2;
		end
		return res;
	endfunction

	class attitude_board;
		logic [CFG_W-1:0] rows[3];
		att_t pending[$];

		function void reset_rows();
			rows[0] = ROW0_RST; rows[1] = ROW1_RST; rows[2] = ROW2_RST;
		endfunction

		function longint b_at(int r, int c);
			logic signed [15:0] e;
			e = rows[r][16*c +: 16];
			return e;
		endfunction

		function att_t predict(est_t e);
			att_t o;
			longint q[4], rm[3][3], s[3][3];
			longint m, n2, d, x, y, z, w, m20, m21, m22, m10, m00, lim, asn, v;
			int len;
			q[0] = e.quat_x; q[1] = e.quat_y; q[2] = e.quat_z; q[3] = e.quat_w;
			m = 0; len = 0;
			foreach (q[i]) begin
				v = q[i] < 0 ? -q[i] : q[i];
				if (v > m) m = v;
			end
			o = '0;
			o.bad_quat = (m == 0);
			if (m != 0) begin
				while (len < 64 && (m >> len) != 0) len++;
				foreach (q[i])
					if (len > 30) q[i] = sra(q[i], len - 30);
					else if (len < 30) q[i] = q[i] * (64'sd1 <<< (30 - len));
				x = q[0]; y = q[1]; z = q[2]; w = q[3];
				n2 = x*x + y*y + z*z + w*w;
				d = longint'(longint'(unsigned'(n2)) >>> 0) >> FRAC;
				d = $unsigned(n2) >> FRAC;
				if (d == 0) d = 1;
				rm[0][0] = (w*w + x*x - y*y - z*z) / d;
				rm[0][1] = (2*(x*y - w*z)) / d;
				rm[0][2] = (2*(x*z + w*y)) / d;
				rm[1][0] = (2*(x*y + w*z)) / d;
				rm[1][1] = (w*w - x*x + y*y - z*z) / d;
				rm[1][2] = (2*(y*z - w*x)) / d;
				rm[2][0] = (2*(x*z - w*y)) / d;
				rm[2][1] = (2*(y*z + w*x)) / d;
				rm[2][2] = (w*w - x*x - y*y + z*z) / d;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						s[i][j] = 0;
						for (int k = 0; k < 3; k++) s[i][j] += rm[i][k] * b_at(j, k);
					end
				m00 = sra(s[1][0], 14); m10 = sra(s[0][0], 14);
				m20 = sra(-s[2][0], 14); m21 = sra(-s[2][1], 14);
				m22 = sra(-s[2][2], 14);
				o.roll = vec_angle(m21, m22);
				o.yaw = vec_angle(m10, m00);
				lim = 64'sd1 <<< FRAC;
				if (m20 > lim) m20 = lim;
				if (m20 < -lim) m20 = -lim;
				asn = vec_angle(m20, int_sqrt(lim*lim - m20*m20));
				if (asn > 16384) asn = 16384;
				if (asn < -16384) asn = -16384;
				o.pitch = -asn;
			end
			o.stamp_out = e.stamp_in; o.gen_out = e.gen_in;
			o.pos_north = e.pos_wy; o.pos_east = e.pos_wx;
			o.pos_down = (e.pos_wz == 32'sh8000_0000) ? 32'sh7fff_ffff : -e.pos_wz;
			o.vel_north = e.vel_wy; o.vel_east = e.vel_wx;
			o.vel_down = (e.vel_wz == 32'sh8000_0000) ? 32'sh7fff_ffff : -e.vel_wz;
			return o;
		endfunction

		function void note_estimate(est_t e);
			pending.push_back(predict(e));
		endfunction

		task check_attitude(att_t g);
			att_t w;
			if (pending.size() == 0) begin
				report("unexpected attitude", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (g.stamp_out !== w.stamp_out) report("stamp_out", g.stamp_out, w.stamp_out);
			if (g.gen_out !== w.gen_out) report("gen_out", g.gen_out, w.gen_out);
			if (g.pos_north !== w.pos_north) report("pos_north", g.pos_north, w.pos_north);
			if (g.pos_east !== w.pos_east) report("pos_east", g.pos_east, w.pos_east);
			if (g.pos_down !== w.pos_down) report("pos_down", g.pos_down, w.pos_down);
			if (g.vel_north !== w.vel_north) report("vel_north", g.vel_north, w.vel_north);
			if (g.vel_east !== w.vel_east) report("vel_east", g.vel_east, w.vel_east);
			if (g.vel_down !== w.vel_down) report("vel_down", g.vel_down, w.vel_down);
			if (g.roll !== w.roll) report("roll", g.roll, w.roll);
			if (g.pitch !== w.pitch) report("pitch", g.pitch, w.pitch);
			if (g.yaw !== w.yaw) report("yaw", g.yaw, w.yaw);
			if (g.bad_quat !== w.bad_quat) report("bad_quat", g.bad_quat, w.bad_quat);
		endtask
	endclass

	attitude_board board = new();

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// receiver: random stalls, an optional long hold-off
	always @(posedge clk) begin
		if (arst_n && att_valid && att_ready) board.check_attitude(att);
		if (hold_go && !hold_done) begin
			hold_done <= 1;
			hold_off <= 300;
			att_ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			att_ready <= 0;
		end else att_ready <= rx_busy_free ? 1'b1 : ($urandom_range(99) >= 13);
	end

	task automatic cfg_write(input int idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(8 * idx); pwdata <= 64'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx < CFG_N) board.rows[idx] = val;
		n_cfg++;
	endtask

	task automatic drain();
		est_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic send(input est_t e, input bit gaps);
		if (gaps) while ($urandom_range(99) < 13) begin
			est_valid <= 0;
			@(posedge clk);
		end
		est_valid <= 1; est <= e;
		do @(posedge clk); while (!est_ready);
		board.note_estimate(e);
		n_sent++;
		if (e.quat_x == 0 && e.quat_y == 0 && e.quat_z == 0 && e.quat_w == 0) n_bad++;
	endtask

	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(64)) - 32);
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	function automatic est_t rnd_est(input int shift);
		est_t e;
		e.quat_x = $signed(rnd_comp()) >>> shift;
		e.quat_y = $signed(rnd_comp()) >>> shift;
		e.quat_z = $signed(rnd_comp()) >>> shift;
		e.quat_w = $signed(rnd_comp()) >>> shift;
		e.pos_wx = rnd_comp(); e.pos_wy = rnd_comp(); e.pos_wz = rnd_comp();
		e.vel_wx = rnd_comp(); e.vel_wy = rnd_comp(); e.vel_wz = rnd_comp();
		e.stamp_in = {$urandom, $urandom};
		e.gen_in = $urandom;
		return e;
	endfunction

	function automatic logic [15:0] q14(input int v);
		return 16'(v);
	endfunction

	task automatic directed();
		est_t e;
		logic [31:0] qs[10][4] = '{
			'{0, 0, 0, 0}, '{0, 0, 0, 1}, '{0, 0, 0, 32'h8000_0000},
			'{32'h7fff_ffff, 0, 0, 0}, '{0, 32'h7fff_ffff, 0, 0}, '{0, 0, 32'h7fff_ffff, 0},
			'{1, 1, 1, 1}, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{0, 32'h5a82_7999, 0, 32'h5a82_7999}, '{0, 32'ha57d_8667, 0, 32'h5a82_7999}};
		foreach (qs[i]) begin
			e = rnd_est(0);
			{e.quat_x, e.quat_y, e.quat_z, e.quat_w} = {qs[i][0], qs[i][1], qs[i][2], qs[i][3]};
			if (i < 2) begin
				e.pos_wz = 32'h8000_0000; e.vel_wz = 32'h8000_0000;
				e.stamp_in = '1; e.gen_in = '1;
			end
			if (i == 2) begin
				e.pos_wz = 32'h7fff_ffff; e.vel_wz = 32'h7fff_ffff;
				e.stamp_in = '0; e.gen_in = '0;
			end
			send(e, 0);
		end
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) send(rnd_est($urandom_range(3) == 0 ? $urandom_range(31) : 0), 1);
	endtask

	initial begin
		board.reset_rows();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		directed();
		drain();
		// rotated mounts, then extremes and raw patterns
		cfg_write(0, {q14(0), q14(16384), q14(0)});
		cfg_write(1, {q14(0), q14(0), q14(-16384)});
		cfg_write(2, {q14(-16384), q14(0), q14(0)});
		directed();
		random_phase(300);
		drain();
		cfg_write(0, 48'hffff_ffff_ffff);
		cfg_write(1, 48'h7fff_7fff_7fff);
		cfg_write(2, 48'h8000_8000_8000);
		random_phase(250);
		// long receiver hold-off with the sender still offering
		hold_go = 1;
		random_phase(200);
		drain();
		cfg_write(0, 48'h0);
		cfg_write(1, 48'h0);
		cfg_write(2, 48'h0);
		random_phase(100);
		drain();
		cfg_write(0, CFG_W'({$urandom, $urandom}));
		cfg_write(1, CFG_W'({$urandom, $urandom}));
		cfg_write(2, CFG_W'({$urandom, $urandom}));
		cfg_write(3, '1);
		random_phase(300);
		drain();
		cfg_write(0, ROW0_RST);
		cfg_write(1, ROW1_RST);
		cfg_write(2, ROW2_RST);
		rx_busy_free = 1;
		for (int i = 0; i < 300; i++) send(rnd_est(0), 0);
		rx_busy_free = 0;
		random_phase(480);
		drain();
		$display("sent %0d estimates (%0d zero quaternions), %0d register writes", n_sent,
			n_bad, n_cfg);
		$display("covered rotated, extreme, zero and random body rows with stalls");
		if (errors == 0 && board.pending.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/q2n_pkg.sv
rtl/q2n_div_cell.sv
rtl/q2n_sqrt_cell.sv
rtl/q2n_cordic_cell.sv
rtl/quaternion_to_ned_attitude_unit.sv
rtl/q2n_checker.sv
test/tb.sv
